>>> hw/rtl/oobvmt_pkg.sv
// oobvmt_pkg: shared types and fixed field widths for the out-of-bag vote tally
// no dependencies; used by oobvmt_scan and oob_vote_margin_tally_core
`timescale 1ns / 1ps

package oobvmt_pkg;

    // fixed widths of the word fields
    localparam int unsigned CLASS_FIELD_W = 4;
    localparam int unsigned CFG_W         = 5;
    localparam int unsigned TALLY_W       = 11;
    localparam int unsigned MARGIN_W      = 12;
    localparam int unsigned S_TDATA_W     = 8;
    localparam int unsigned M_TDATA_W     = 32;
    localparam int unsigned TALLY_LIMIT   = 2047;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // control from the sequencer to the scan datapath
    typedef struct packed {
        logic clear;
        logic issue;
    } scan_ctrl_t;

endpackage

>>> hw/rtl/oobvmt_ram.sv
// oobvmt_ram: generic single-write, single-read ram with registered read data
// read-first on a same-address write; no dependencies
`timescale 1ns / 1ps

module oobvmt_ram #(
    parameter int unsigned WIDTH = 11,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/oobvmt_scan.sv
// oobvmt_scan: end-of-sample scan over the tally read stream
// tracks majority, runner-up and true-class votes; uses oobvmt_pkg
`timescale 1ns / 1ps

module oobvmt_scan #(
    parameter int unsigned MAX_CLASSES = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  oobvmt_pkg::scan_ctrl_t                  ctrl,
    input  logic [$clog2(MAX_CLASSES)-1:0]          issue_idx,
    input  logic [$clog2(MAX_CLASSES+1)-1:0]        n_classes,
    input  logic [oobvmt_pkg::CLASS_FIELD_W-1:0]    true_class,
    input  logic [oobvmt_pkg::TALLY_W-1:0]          rd_data,
    output logic [$clog2(MAX_CLASSES)-1:0]          best_cls,
    output logic [$clog2(MAX_CLASSES)-1:0]          run_cls,
    output logic [oobvmt_pkg::TALLY_W-1:0]          run_votes,
    output logic [oobvmt_pkg::TALLY_W-1:0]          true_votes
);

    localparam int unsigned CW = $clog2(MAX_CLASSES);

    logic                             proc_valid_reg;
    logic [CW-1:0]                    proc_idx_reg;
    logic [oobvmt_pkg::TALLY_W-1:0]   best_reg;
    logic [CW-1:0]                    best_cls_reg;
    logic [oobvmt_pkg::TALLY_W-1:0]   run_reg;
    logic [CW-1:0]                    run_cls_reg;
    logic                             run_set_reg;
    logic [oobvmt_pkg::TALLY_W-1:0]   true_reg;
    logic                             in_use;
    logic                             is_true;

    assign in_use  = 32'(proc_idx_reg) < 32'(n_classes);
    assign is_true = 32'(proc_idx_reg) == 32'(true_class);

    // read data arrives in the cycle after the address is issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_valid_reg <= 1'b0;
        end
        else
        begin
            proc_valid_reg <= ctrl.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= issue_idx;
        if (ctrl.clear)
        begin
            best_reg     <= '0;
            best_cls_reg <= '0;
            run_reg      <= '0;
            run_cls_reg  <= '0;
            run_set_reg  <= 1'b0;
            true_reg     <= '0;
        end
        else if (proc_valid_reg && in_use)
        begin
            if (rd_data > best_reg)
            begin
                best_reg     <= rd_data;
                best_cls_reg <= proc_idx_reg;
            end
            if (is_true)
            begin
                true_reg <= rd_data;
            end
            else if (!run_set_reg || rd_data > run_reg)
            begin
                run_reg     <= rd_data;
                run_cls_reg <= proc_idx_reg;
                run_set_reg <= 1'b1;
            end
        end
    end

    assign best_cls   = best_cls_reg;
    assign run_cls    = run_cls_reg;
    assign run_votes  = run_reg;
    assign true_votes = true_reg;

endmodule

>>> hw/rtl/oob_vote_margin_tally_core.sv
// oob_vote_margin_tally_core: out-of-bag vote tally, majority class and margin
// a last vote goes through update, scan, drain and result load before m_tvalid
// a new vote word is not taken until the tally ram read-modify-write of the last one is done
// a last-tree word scans one tally entry a cycle, then drains and loads the result
// reset: async active low; clears control, then a clearing pass zeroes the tally ram,
// during which s_tready is low; class_count resets to 2
`timescale 1ns / 1ps

module oob_vote_margin_tally_core #(
    parameter int unsigned MAX_CLASSES = 16,
    parameter int unsigned MAX_TREES   = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration: class_count
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [oobvmt_pkg::CFG_W-1:0]         cfg_data,
    // vote words
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [oobvmt_pkg::S_TDATA_W-1:0]     s_tdata,  // vote_class[3:0], true_class[7:4]
    input  logic                                 s_tuser,  // vote_valid
    input  logic                                 s_tlast,  // last_tree
    // result words
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // voted_class[3:0], runner_up_class[7:4], margin_count[19:8], vote_count[30:20], zero pad
    output logic [oobvmt_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tuser   // has_vote
);

    localparam int unsigned CW  = $clog2(MAX_CLASSES);
    localparam int unsigned NW  = $clog2(MAX_CLASSES + 1);
    localparam int unsigned CAP = (MAX_TREES < oobvmt_pkg::TALLY_LIMIT) ?
                                  MAX_TREES : oobvmt_pkg::TALLY_LIMIT;
    localparam int unsigned TW  = oobvmt_pkg::TALLY_W;
    localparam int unsigned FW  = oobvmt_pkg::CLASS_FIELD_W;

    oobvmt_pkg::state_t state_reg, state_next;

    logic [oobvmt_pkg::CFG_W-1:0]  class_count_reg;
    logic [NW-1:0]                 n_classes;

    // current word held across the read-modify-write
    logic                          vote_ok_reg;
    logic [CW-1:0]                 vcls_reg;
    logic [FW-1:0]                 tcls_reg;
    logic                          last_reg;

    logic [TW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 idx_reg, idx_next;

    // ram port
    logic                          ram_we;
    logic [CW-1:0]                 ram_wr_addr;
    logic [TW-1:0]                 ram_wr_data;
    logic [CW-1:0]                 ram_rd_addr;
    logic [TW-1:0]                 ram_rd_data;

    // scan results
    oobvmt_pkg::scan_ctrl_t        scan_ctrl;
    logic [CW-1:0]                 best_cls;
    logic [CW-1:0]                 run_cls;
    logic [TW-1:0]                 run_votes;
    logic [TW-1:0]                 true_votes;

    // output register
    logic                          m_valid_reg;
    logic [oobvmt_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                          m_user_reg;
    logic                          load_out;
    logic [oobvmt_pkg::MARGIN_W-1:0] margin;
    logic                          in_accept;
    logic [FW-1:0]                 in_vote_class;
    logic [FW-1:0]                 in_true_class;

    assign in_vote_class = s_tdata[FW-1:0];
    assign in_true_class = s_tdata[2*FW-1:FW];

    // classes in use: class_count clamped to 2 .. MAX_CLASSES
    always_comb
    begin
        if (class_count_reg < oobvmt_pkg::CFG_W'(2))
        begin
            n_classes = NW'(2);
        end
        else if (32'(class_count_reg) > MAX_CLASSES)
        begin
            n_classes = NW'(MAX_CLASSES);
        end
        else
        begin
            n_classes = NW'(class_count_reg);
        end
    end

    // config is taken while no word is in flight, including the reset clearing pass
    assign cfg_ready = (state_reg == oobvmt_pkg::ST_IDLE) ||
                       (state_reg == oobvmt_pkg::ST_CLEAR);
    assign s_tready  = (state_reg == oobvmt_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= oobvmt_pkg::CFG_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            class_count_reg <= cfg_data;
        end
    end

    // capture the vote; the class test uses the class count at acceptance
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            vote_ok_reg <= s_tuser && (32'(in_vote_class) < 32'(n_classes));
            vcls_reg    <= CW'(in_vote_class);
            tcls_reg    <= in_true_class;
            last_reg    <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oobvmt_pkg::ST_CLEAR;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // sequencer: clear pass, vote update, scan with clear-behind, result
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = '0;
        ram_rd_addr     = idx_reg;
        scan_ctrl.clear = 1'b0;
        scan_ctrl.issue = 1'b0;
        load_out        = 1'b0;

        unique case (state_reg)
            oobvmt_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (32'(idx_reg) == MAX_CLASSES - 1)
                begin
                    idx_next   = '0;
                    state_next = oobvmt_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            oobvmt_pkg::ST_IDLE:
            begin
                ram_rd_addr = CW'(in_vote_class);
                if (in_accept)
                begin
                    state_next = oobvmt_pkg::ST_UPD;
                end
            end

            oobvmt_pkg::ST_UPD:
            begin
                ram_wr_addr = vcls_reg;
                if (vote_ok_reg)
                begin
                    ram_we = 1'b1;
                    if (32'(ram_rd_data) < CAP)
                    begin
                        ram_wr_data = ram_rd_data + TW'(1);
                    end
                    else
                    begin
                        ram_wr_data = ram_rd_data;
                    end
                    if (32'(count_reg) < CAP)
                    begin
                        count_next = count_reg + TW'(1);
                    end
                end
                if (last_reg)
                begin
                    scan_ctrl.clear = 1'b1;
                    idx_next        = '0;
                    state_next      = oobvmt_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = oobvmt_pkg::ST_IDLE;
                end
            end

            oobvmt_pkg::ST_SCAN:
            begin
                // read each entry and zero it behind the read
                ram_we          = 1'b1;
                scan_ctrl.issue = 1'b1;
                if (32'(idx_reg) == MAX_CLASSES - 1)
                begin
                    idx_next   = '0;
                    state_next = oobvmt_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            oobvmt_pkg::ST_DRAIN:
            begin
                state_next = oobvmt_pkg::ST_DONE;
            end

            oobvmt_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    count_next = '0;
                    state_next = oobvmt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = oobvmt_pkg::ST_IDLE;
            end
        endcase
    end

    oobvmt_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_CLASSES)
    ) u_tally_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    oobvmt_scan #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .issue_idx  (idx_reg),
        .n_classes  (n_classes),
        .true_class (tcls_reg),
        .rd_data    (ram_rd_data),
        .best_cls   (best_cls),
        .run_cls    (run_cls),
        .run_votes  (run_votes),
        .true_votes (true_votes)
    );

    // margin wraps into 12 bits two's complement
    assign margin = oobvmt_pkg::MARGIN_W'(true_votes) - oobvmt_pkg::MARGIN_W'(run_votes);

    // output register: the next vote word may be taken while a result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (count_reg == '0)
            begin
                // no out-of-bag vote: every field reads zero
                m_data_reg <= '0;
                m_user_reg <= 1'b0;
            end
            else
            begin
                m_data_reg <= oobvmt_pkg::M_TDATA_W'({count_reg, margin,
                                                      FW'(run_cls), FW'(best_cls)});
                m_user_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
